>>> rtl/core/bsp_point_location_defines.svh
// Assertion macros for the BSP point location block.
`ifndef BSP_POINT_LOCATION_DEFINES_SVH
`define BSP_POINT_LOCATION_DEFINES_SVH

`ifndef SYNTH
`define BSPPL_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bsppl check failed");
`define BSPPL_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bsppl check failed");
`else
`define BSPPL_ASSERT_IMP(label, ante, cons)
`define BSPPL_ASSERT_NXT(label, ante, cons)
`endif

`endif

>>> rtl/core/bsppl_pkg.sv
// Shared types and constants for the BSP point location block.
`default_nettype none

package bsppl_pkg;

	localparam int NODES_DEFAULT = 4096;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_LOCATE = 1'b1;

	localparam logic REG_NODE_COUNT = 1'b0;

	localparam int COORD_W = 16;
	localparam int CHILD_W = 16;
	localparam int SUB_W   = 15;
	localparam int COUNT_W = 13;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] dx;
		logic signed [COORD_W-1:0] dy;
		logic [CHILD_W-1:0]        child_front;
		logic [CHILD_W-1:0]        child_back;
	} node_t;

	typedef struct packed {
		logic                      use_fast;
		logic                      fast_side;
		logic signed [31:0]        left;
		logic signed [31:0]        right;
		logic [CHILD_W-1:0]        child_front;
		logic [CHILD_W-1:0]        child_back;
	} side_res_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_TEST,
		S_PICK,
		S_EMIT
	} state_t;

endpackage

`default_nettype wire

>>> rtl/core/bsp_point_location.sv
// Top level of the BSP point location block: control, config register and result register.
//
//  channel   dir  handshake                 content
//  s_axis    in   tvalid/tready             node write or point locate request
//  m_axis    out  tvalid/tready             subsector, fault flag
//  apb       in   psel/penable, pready=1    node_count register
//
// A node write goes to the table as it is accepted. A locate issues the root read as it
// is accepted; each tree level then passes S_TEST (side test on the read node, registered)
// and S_PICK (child select and next table read), and S_EMIT hands the result to the output
// register; an empty tree goes straight to S_EMIT. Reset clears control state only; the
// table holds garbage until written. A stalled output holds the finished result while the
// next request is taken.
`default_nettype none

`include "bsp_point_location_defines.svh"

module bsp_point_location #(
	parameter int NODES = bsppl_pkg::NODES_DEFAULT
) (
	input  wire logic         clk,
	input  wire logic         arst_n,

	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// node_index[11:0], line_x[27:12], line_y[43:28], line_dx[59:44], line_dy[75:60],
	// child_front[91:76], child_back[107:92], query_x[123:108], query_y[139:124], zero pad
	input  wire logic [143:0] s_axis_tdata,
	// command[0]
	input  wire logic [0:0]   s_axis_tuser,

	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// subsector[14:0], zero pad
	output logic [15:0]       m_axis_tdata,
	// walk_fault[0]
	output logic [0:0]        m_axis_tuser,

	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam logic [AW-1:0] LAST_STEP = AW'(NODES - 1);

	bsppl_pkg::state_t state_q;
	bsppl_pkg::state_t state_nxt;

	logic [bsppl_pkg::COUNT_W-1:0] node_count_q;
	logic                          cfg_wr;

	logic                          in_acc;
	logic                          cmd;
	logic [11:0]                   in_index;
	bsppl_pkg::node_t              in_node;
	logic signed [15:0]            in_qx;
	logic signed [15:0]            in_qy;

	logic                          wr_en;
	logic                          rd_en;
	logic [AW-1:0]                 rd_addr;
	bsppl_pkg::node_t              rd_data;

	logic signed [15:0]            qx_q;
	logic signed [15:0]            qy_q;
	logic [AW-1:0]                 steps_q;
	logic [bsppl_pkg::SUB_W-1:0]   res_sub_q;
	logic                          res_fault_q;

	logic                          out_valid_q;
	logic [bsppl_pkg::SUB_W-1:0]   out_sub_q;
	logic                          out_fault_q;

	bsppl_pkg::side_res_t          side_s2;
	logic                          side;
	logic [bsppl_pkg::CHILD_W-1:0] child;
	logic                          leaf;
	logic                          last;
	logic                          child_ok;
	logic                          tree_empty;
	logic                          root_ok;
	logic [bsppl_pkg::COUNT_W-1:0] root;
	logic                          emit_load;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == bsppl_pkg::REG_NODE_COUNT);
	assign prdata = (paddr[2] == bsppl_pkg::REG_NODE_COUNT) ? 32'(node_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
		end else if (cfg_wr) begin
			node_count_q <= pwdata[bsppl_pkg::COUNT_W-1:0];
		end
	end

	// input unpack
	assign s_axis_tready       = (state_q == bsppl_pkg::S_IDLE);
	assign in_acc              = s_axis_tvalid & s_axis_tready;
	assign cmd                 = s_axis_tuser[0];
	assign in_index            = s_axis_tdata[11:0];
	assign in_node.x           = s_axis_tdata[27:12];
	assign in_node.y           = s_axis_tdata[43:28];
	assign in_node.dx          = s_axis_tdata[59:44];
	assign in_node.dy          = s_axis_tdata[75:60];
	assign in_node.child_front = s_axis_tdata[91:76];
	assign in_node.child_back  = s_axis_tdata[107:92];
	assign in_qx               = s_axis_tdata[123:108];
	assign in_qy               = s_axis_tdata[139:124];

	assign wr_en      = in_acc && (cmd == bsppl_pkg::CMD_WRITE) && (32'(in_index) < NODES);
	assign tree_empty = (node_count_q == '0);
	assign root       = node_count_q - 1'b1;
	assign root_ok    = (32'(node_count_q) <= NODES);

	// walk decision
	assign side     = side_s2.use_fast ? side_s2.fast_side : (side_s2.right >= side_s2.left);
	assign child    = side ? side_s2.child_back : side_s2.child_front;
	assign leaf     = child[bsppl_pkg::CHILD_W-1];
	assign last     = (steps_q == LAST_STEP);
	assign child_ok = (32'(child[bsppl_pkg::SUB_W-1:0]) < NODES);

	assign emit_load = (state_q == bsppl_pkg::S_EMIT) && (!out_valid_q || m_axis_tready);

	bsppl_node_mem #(
		.NODES (NODES),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(in_index)),
		.wr_data (in_node),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	bsppl_side u_side (
		.clk    (clk),
		.node   (rd_data),
		.qx     (qx_q),
		.qy     (qy_q),
		.res_s2 (side_s2)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			bsppl_pkg::S_IDLE: begin
				if (in_acc && (cmd == bsppl_pkg::CMD_LOCATE)) begin
					state_nxt = (tree_empty || !root_ok) ? bsppl_pkg::S_EMIT
						: bsppl_pkg::S_TEST;
				end
			end
			bsppl_pkg::S_TEST: begin
				state_nxt = bsppl_pkg::S_PICK;
			end
			bsppl_pkg::S_PICK: begin
				state_nxt = (leaf || last || !child_ok) ? bsppl_pkg::S_EMIT
					: bsppl_pkg::S_TEST;
			end
			bsppl_pkg::S_EMIT: begin
				if (!out_valid_q || m_axis_tready) begin
					state_nxt = bsppl_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = bsppl_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			bsppl_pkg::S_IDLE: begin
				if (in_acc && (cmd == bsppl_pkg::CMD_LOCATE) && !tree_empty && root_ok) begin
					rd_en   = 1'b1;
					rd_addr = AW'(root);
				end
			end
			bsppl_pkg::S_PICK: begin
				if (!leaf && !last && child_ok) begin
					rd_en   = 1'b1;
					rd_addr = AW'(child[bsppl_pkg::SUB_W-1:0]);
				end
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsppl_pkg::S_IDLE;
			steps_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == bsppl_pkg::S_IDLE) begin
				steps_q <= '0;
			end else if (state_q == bsppl_pkg::S_PICK && !last) begin
				steps_q <= steps_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && (cmd == bsppl_pkg::CMD_LOCATE)) begin
			qx_q        <= in_qx;
			qy_q        <= in_qy;
			res_sub_q   <= '0;
			res_fault_q <= !tree_empty && !root_ok;
		end else if (state_q == bsppl_pkg::S_PICK) begin
			res_sub_q   <= leaf ? child[bsppl_pkg::SUB_W-1:0] : '0;
			res_fault_q <= !leaf;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_sub_q   <= res_sub_q;
			out_fault_q <= res_fault_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = 16'(out_sub_q);
	assign m_axis_tuser  = out_fault_q;

	`BSPPL_ASSERT_IMP(a_pick_after_test, state_q == bsppl_pkg::S_PICK, $past(state_q) == bsppl_pkg::S_TEST)
	`BSPPL_ASSERT_IMP(a_fault_zero_sub, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 16'd0)
	`BSPPL_ASSERT_NXT(a_empty_tree, in_acc && (cmd == bsppl_pkg::CMD_LOCATE) && tree_empty, state_q == bsppl_pkg::S_EMIT && res_sub_q == '0 && !res_fault_q)

endmodule

`default_nettype wire

>>> rtl/core/bsppl_node_mem.sv
// Node table: one write port, one registered read port.
`default_nettype none

module bsppl_node_mem #(
	parameter int NODES = bsppl_pkg::NODES_DEFAULT,
	parameter int AW    = 12
) (
	input  wire logic            clk,
	input  wire logic            wr_en,
	input  wire logic [AW-1:0]   wr_addr,
	input  wire bsppl_pkg::node_t wr_data,
	input  wire logic            rd_en,
	input  wire logic [AW-1:0]   rd_addr,
	output bsppl_pkg::node_t     rd_data
);

	bsppl_pkg::node_t mem [NODES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/bsppl_side.sv
// Partition side test: special cases, sign shortcut and cross products, one register stage.
`default_nettype none

module bsppl_side (
	input  wire logic                    clk,
	input  wire bsppl_pkg::node_t        node,
	input  wire logic signed [15:0]      qx,
	input  wire logic signed [15:0]      qy,
	output bsppl_pkg::side_res_t         res_s2
);

	logic signed [15:0] ex;
	logic signed [15:0] ey;
	logic               sgn;
	logic               use_fast;
	logic               fast_side;

	always_comb begin
		ex  = qx - node.x;
		ey  = qy - node.y;
		sgn = node.dy[15] ^ node.dx[15] ^ ex[15] ^ ey[15];
		priority if (node.dx == '0) begin
			use_fast  = 1'b1;
			fast_side = (qx <= node.x) ? (node.dy > 16'sd0) : (node.dy < 16'sd0);
		end else if (node.dy == '0) begin
			use_fast  = 1'b1;
			fast_side = (qy <= node.y) ? (node.dx < 16'sd0) : (node.dx > 16'sd0);
		end else if (sgn) begin
			use_fast  = 1'b1;
			fast_side = node.dy[15] ^ ex[15];
		end else begin
			use_fast  = 1'b0;
			fast_side = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		res_s2.use_fast    <= use_fast;
		res_s2.fast_side   <= fast_side;
		res_s2.left        <= 32'(node.dy) * 32'(ex);
		res_s2.right       <= 32'(ey) * 32'(node.dx);
		res_s2.child_front <= node.child_front;
		res_s2.child_back  <= node.child_back;
	end

endmodule

`default_nettype wire

>>> verif/bsp_point_location_tb.sv
// Self-checking testbench for bsp_point_location: random BSP trees, point walks, APB setup.
`timescale 1ns / 100ps

module bsp_point_location_tb;

	localparam int NODES = bsppl_pkg::NODES_DEFAULT;
	localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int STALL_LIMIT = 40000;
	localparam int TREE_N = 200;
	localparam int CALM_LO = 700;
	localparam int CALM_HI = 1100;
	localparam logic [2:0] NODE_COUNT_ADDR = {bsppl_pkg::REG_NODE_COUNT, 2'b00};
	localparam logic [2:0] REG_SPARE_ADDR = 3'd4;

	typedef enum logic [1:0] {
		K_SEND,
		K_CFG,
		K_RD,
		K_PAUSE
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic               cmd;
		logic [11:0]        node_index;
		bsppl_pkg::node_t   line;
		logic signed [15:0] qx;
		logic signed [15:0] qy;
		logic [2:0]         addr;
		logic [31:0]        val;
	} bsp_req_t;

	typedef struct packed {
		logic [14:0] subsector;
		logic        walk_fault;
	} locate_res_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	// node_index[11:0], line_x[27:12], line_y[43:28], line_dx[59:44], line_dy[75:60],
	// child_front[91:76], child_back[107:92], query_x[123:108], query_y[139:124], zero pad
	logic [143:0] s_axis_tdata = '0;
	// command[0]
	logic [0:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// subsector[14:0], zero pad
	logic [15:0]  m_axis_tdata;
	// walk_fault[0]
	logic [0:0]   m_axis_tuser;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	bsp_req_t         pend_q [$];
	locate_res_t      exp_q [$];
	bsppl_pkg::node_t m_tab [NODES];
	logic [12:0]      m_count = '0;

	logic [1:0]       apb_phase = 2'd0;
	int               acc_cnt = 0;
	int               err_cnt = 0;
	int               stall_cnt = 0;
	int               end_cnt = 0;
	logic             calm;

	assign calm = (acc_cnt >= CALM_LO) && (acc_cnt < CALM_HI);

	function automatic logic [15:0] rand_coord();
		if ($urandom_range(0, 99) < 30) begin
			return 16'($urandom_range(0, 16)) - 16'd8;
		end
		return 16'($urandom);
	endfunction

	function automatic bsppl_pkg::node_t rand_line();
		bsppl_pkg::node_t n;
		int unsigned      sel;
		n    = '0;
		n.x  = rand_coord();
		n.y  = rand_coord();
		n.dx = rand_coord();
		n.dy = rand_coord();
		sel  = $urandom_range(0, 11);
		if (sel == 0) begin
			n.dx = '0;
		end else if (sel == 1) begin
			n.dy = '0;
		end else if (sel == 2) begin
			n.dx = '0;
			n.dy = '0;
		end else if (sel == 3) begin
			n.dx = 16'sh8000;
		end else if (sel == 4) begin
			n.dy = 16'sh8000;
		end
		return n;
	endfunction

	// non-leaf children point below lim or past the end of the table, so every reachable entry is written
	function automatic logic [15:0] rand_child(input int lim);
		int unsigned r;
		int          lo;
		r = $urandom_range(0, 99);
		if (lim == 0 || r < 25) begin
			return {1'b1, 15'($urandom)};
		end
		if (r < 28) begin
			return 16'($urandom_range(NODES, 32767));
		end
		if (r < 64) begin
			lo = (lim > 8) ? lim - 8 : 0;
			return 16'($urandom_range(lo, lim - 1));
		end
		return 16'($urandom_range(0, lim - 1));
	endfunction

	function automatic void push_write(input int idx, input bsppl_pkg::node_t n);
		bsp_req_t r;
		r            = '0;
		r.kind       = K_SEND;
		r.cmd        = bsppl_pkg::CMD_WRITE;
		r.node_index = 12'(idx);
		r.line       = n;
		r.qx         = rand_coord();
		r.qy         = rand_coord();
		pend_q.push_back(r);
	endfunction

	function automatic void push_tree_node(input int idx, input int lim);
		bsppl_pkg::node_t n;
		n             = rand_line();
		n.child_front = rand_child(lim);
		n.child_back  = rand_child(lim);
		push_write(idx, n);
	endfunction

	function automatic void push_locate();
		bsp_req_t r;
		r            = '0;
		r.kind       = K_SEND;
		r.cmd        = bsppl_pkg::CMD_LOCATE;
		r.node_index = 12'($urandom);
		r.line       = rand_line();
		r.qx         = rand_coord();
		r.qy         = rand_coord();
		pend_q.push_back(r);
	endfunction

	function automatic void push_cfg(input logic [2:0] addr, input logic [31:0] val);
		bsp_req_t r;
		r      = '0;
		r.kind = K_CFG;
		r.addr = addr;
		r.val  = val;
		pend_q.push_back(r);
	endfunction

	function automatic void push_read();
		bsp_req_t r;
		r      = '0;
		r.kind = K_RD;
		r.addr = NODE_COUNT_ADDR;
		pend_q.push_back(r);
	endfunction

	function automatic void push_pause();
		bsp_req_t r;
		r      = '0;
		r.kind = K_PAUSE;
		pend_q.push_back(r);
	endfunction

	function automatic logic [143:0] pack_req(input bsp_req_t r);
		logic [143:0] d;
		d           = '0;
		d[11:0]     = r.node_index;
		d[27:12]    = r.line.x;
		d[43:28]    = r.line.y;
		d[59:44]    = r.line.dx;
		d[75:60]    = r.line.dy;
		d[91:76]    = r.line.child_front;
		d[107:92]   = r.line.child_back;
		d[123:108]  = r.qx;
		d[139:124]  = r.qy;
		return d;
	endfunction

	function automatic logic side_of(input bsppl_pkg::node_t e, input logic signed [15:0] qx,
			input logic signed [15:0] qy);
		logic signed [15:0] ex;
		logic signed [15:0] ey;
		logic signed [31:0] lft;
		logic signed [31:0] rgt;
		if (e.dx == 16'sd0) begin
			return (qx <= e.x) ? (e.dy > 16'sd0) : (e.dy < 16'sd0);
		end
		if (e.dy == 16'sd0) begin
			return (qy <= e.y) ? (e.dx < 16'sd0) : (e.dx > 16'sd0);
		end
		ex = qx - e.x;
		ey = qy - e.y;
		if (e.dy[15] ^ e.dx[15] ^ ex[15] ^ ey[15]) begin
			return e.dy[15] ^ ex[15];
		end
		lft = $signed({{16{e.dy[15]}}, e.dy}) * $signed({{16{ex[15]}}, ex});
		rgt = $signed({{16{ey[15]}}, ey}) * $signed({{16{e.dx[15]}}, e.dx});
		return (rgt < lft) ? 1'b0 : 1'b1;
	endfunction

	function automatic void ref_locate(input logic signed [15:0] qx, input logic signed [15:0] qy,
			output logic [14:0] sub, output logic flt);
		int unsigned idx;
		int unsigned steps;
		logic [15:0] child;
		logic        s;
		sub = '0;
		flt = 1'b0;
		if (m_count == '0) begin
			return;
		end
		flt = 1'b1;
		idx = {19'd0, m_count} - 32'd1;
		for (steps = 0; steps < NODES; steps++) begin
			if (idx >= NODES) begin
				break;
			end
			s     = side_of(m_tab[idx[AW-1:0]], qx, qy);
			child = s ? m_tab[idx[AW-1:0]].child_back : m_tab[idx[AW-1:0]].child_front;
			if (child[15]) begin
				sub = child[14:0];
				flt = 1'b0;
				break;
			end
			idx = {16'd0, child};
		end
	endfunction

	bsp_point_location #(
		.NODES (NODES)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #6 clk = ~clk;

	initial begin : gen
		bsppl_pkg::node_t n;
		int               i;
		// empty tree
		push_cfg(NODE_COUNT_ADDR, 32'd0);
		for (i = 0; i < 20; i++) begin
			push_locate();
		end
		// tree build and walks
		for (i = 0; i < TREE_N; i++) begin
			push_tree_node(i, i);
		end
		push_cfg(NODE_COUNT_ADDR, 32'(TREE_N));
		push_read();
		for (i = 0; i < 300; i++) begin
			push_locate();
		end
		// node rewrites mixed with walks
		for (i = 0; i < 400; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				n = '0;
				push_tree_node(int'($urandom_range(0, TREE_N - 1)), 0);
			end else begin
				push_locate();
			end
		end
		push_pause();
		// root at the last table entry
		push_tree_node(NODES - 1, TREE_N);
		push_cfg(NODE_COUNT_ADDR, 32'(NODES));
		for (i = 0; i < 200; i++) begin
			push_locate();
		end
		// root beyond the table
		push_cfg(NODE_COUNT_ADDR, 32'(NODES + 904));
		push_read();
		for (i = 0; i < 10; i++) begin
			push_locate();
		end
		push_cfg(REG_SPARE_ADDR, 32'd7);
		push_read();
		for (i = 0; i < 5; i++) begin
			push_locate();
		end
		// self loop runs into the step bound
		n             = rand_line();
		n.child_front = 16'(TREE_N + 100);
		n.child_back  = 16'(TREE_N + 100);
		push_write(TREE_N + 100, n);
		push_cfg(NODE_COUNT_ADDR, 32'(TREE_N + 101));
		for (i = 0; i < 3; i++) begin
			push_locate();
		end
		push_cfg(NODE_COUNT_ADDR, 32'(TREE_N));
		for (i = 0; i < 450; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				push_tree_node(int'($urandom_range(0, TREE_N - 1)), 0);
			end else begin
				push_locate();
			end
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver
	always @(posedge clk) begin : drv
		bsp_req_t head;
		logic     idle;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			psel          <= 1'b0;
			penable       <= 1'b0;
			pwrite        <= 1'b0;
			apb_phase     <= 2'd0;
		end else if (apb_phase == 2'd1) begin
			penable   <= 1'b1;
			apb_phase <= 2'd2;
		end else if (apb_phase == 2'd2) begin
			psel      <= 1'b0;
			penable   <= 1'b0;
			pwrite    <= 1'b0;
			apb_phase <= 2'd0;
		end else if (s_axis_tvalid && !s_axis_tready) begin
			s_axis_tvalid <= 1'b1;
		end else if (pend_q.size() == 0) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			idle = !calm && ($urandom_range(0, 99) < 20);
			head = pend_q[0];
			unique case (head.kind)
				K_SEND: begin
					if (idle) begin
						s_axis_tvalid <= 1'b0;
					end else begin
						s_axis_tvalid <= 1'b1;
						s_axis_tdata  <= pack_req(head);
						s_axis_tuser  <= head.cmd;
						void'(pend_q.pop_front());
					end
				end
				K_CFG, K_RD: begin
					s_axis_tvalid <= 1'b0;
					if (!s_axis_tvalid && exp_q.size() == 0) begin
						psel      <= 1'b1;
						penable   <= 1'b0;
						pwrite    <= (head.kind == K_CFG);
						paddr     <= head.addr;
						pwdata    <= head.val;
						apb_phase <= 2'd1;
						void'(pend_q.pop_front());
					end
				end
				K_PAUSE: begin
					s_axis_tvalid <= 1'b0;
					if (!s_axis_tvalid && exp_q.size() == 0) begin
						void'(pend_q.pop_front());
					end
				end
			endcase
		end
	end

	// result sink
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm || ($urandom_range(0, 99) >= 20);
		end
	end

	// monitor and predictor
	always @(posedge clk) begin : mon
		bsppl_pkg::node_t w;
		logic [11:0]      w_idx;
		logic [14:0]      e_sub;
		logic             e_flt;
		locate_res_t      exp_r;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (exp_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual sub=%0d fault=%0d",
						$time, m_axis_tdata, m_axis_tuser[0]);
					err_cnt = err_cnt + 1;
				end else begin
					exp_r = exp_q.pop_front();
					if (m_axis_tdata !== {1'b0, exp_r.subsector} ||
							m_axis_tuser[0] !== exp_r.walk_fault) begin
						$display("%0t: result mismatch, expected sub=%0d fault=%0d, actual sub=%0d fault=%0d",
							$time, exp_r.subsector, exp_r.walk_fault, m_axis_tdata,
							m_axis_tuser[0]);
						err_cnt = err_cnt + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				acc_cnt <= acc_cnt + 1;
				if (s_axis_tuser[0] == bsppl_pkg::CMD_WRITE) begin
					w_idx         = s_axis_tdata[11:0];
					w.x           = s_axis_tdata[27:12];
					w.y           = s_axis_tdata[43:28];
					w.dx          = s_axis_tdata[59:44];
					w.dy          = s_axis_tdata[75:60];
					w.child_front = s_axis_tdata[91:76];
					w.child_back  = s_axis_tdata[107:92];
					if (32'(w_idx) < NODES) begin
						m_tab[AW'(w_idx)] = w;
					end
				end else begin
					ref_locate(s_axis_tdata[123:108], s_axis_tdata[139:124], e_sub, e_flt);
					exp_q.push_back({e_sub, e_flt});
				end
			end
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == bsppl_pkg::REG_NODE_COUNT) begin
						m_count = pwdata[12:0];
					end
				end else if (paddr[2] == bsppl_pkg::REG_NODE_COUNT) begin
					if (prdata !== {19'd0, m_count}) begin
						$display("%0t: register read mismatch, expected %0d, actual %0d",
							$time, m_count, prdata);
						err_cnt = err_cnt + 1;
					end
				end
			end
		end
	end

	// watchdog and end of run
	always @(posedge clk) begin
		if (!arst_n) begin
			stall_cnt <= 0;
			end_cnt   <= 0;
		end else begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(psel && penable)) begin
				stall_cnt <= 0;
			end else begin
				stall_cnt <= stall_cnt + 1;
			end
			if (stall_cnt >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, stall_cnt);
				$display("TB_ERROR");
				$finish;
			end
			if (pend_q.size() == 0 && !s_axis_tvalid && !psel && exp_q.size() == 0) begin
				end_cnt <= end_cnt + 1;
			end else begin
				end_cnt <= 0;
			end
			if (end_cnt == 20) begin
				if (err_cnt == 0) begin
					$display("TB_OK");
				end else begin
					$display("TB_ERROR");
				end
				$finish;
			end
		end
	end

endmodule
